// File: rtl/core/periodic_task_release_scheduler_defines.svh
// assertion macros shared by the periodic task release scheduler rtl
`ifndef PERIODIC_TASK_RELEASE_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_RELEASE_SCHEDULER_DEFINES_SVH

// property must hold at every clock edge outside reset
`define PTRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define PTRS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: rtl/core/ptrs_pkg.sv
// types, constants and helpers of the periodic task release scheduler
`default_nettype none

package ptrs_pkg;

  localparam int NUM_TASKS = 4;
  localparam int NUM_REGS  = 4;
  localparam int TASK_W    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CNT_W     = 16;
  localparam int AMT_W     = 8;
  localparam int ID_W      = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [TASK_W-1:0] LAST_TASK = TASK_W'(NUM_TASKS - 1);

  localparam logic [CNT_W-1:0] RESET_INTERVAL [NUM_REGS] = '{
    16'd5, 16'd20, 16'd200, 16'd2000
  };

  // input item kinds
  localparam logic KIND_TICK     = 1'b0;
  localparam logic KIND_DISPATCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_DISP,
    ST_NONE
  } state_e;

  typedef struct packed {
    logic              rd_en;
    logic [TASK_W-1:0] rd_addr;
    logic              wr_en;
    logic [TASK_W-1:0] wr_addr;
    logic [CNT_W-1:0]  wr_data;
  } mem_req_t;

  // task index to the id field, masked to its width
  function automatic logic [ID_W-1:0] task_to_id(input logic [TASK_W-1:0] idx);
    logic [TASK_W+ID_W-1:0] wide;
    wide = (TASK_W + ID_W)'(idx);
    return wide[ID_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ptrs_count_mem.sv
// elapsed counter store: simple dual port ram (one read, one write) with per-entry valid bits
`default_nettype none

module ptrs_count_mem import ptrs_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire mem_req_t         req_i,
  output logic [CNT_W-1:0]      rd_data_o
);

  logic [CNT_W-1:0]     mem [NUM_TASKS];
  logic [NUM_TASKS-1:0] vld_q;
  logic [CNT_W-1:0]     rd_data_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// File: rtl/core/periodic_task_release_scheduler.sv
// periodic task release scheduler top level
// tick item: one counter read per task plus one write-back, the input stalled while busy;
//   the next item is taken in the cycle after the last write-back
// dispatch item: one result per pending task (a single none-ready result if none is pending),
//   one per cycle while the output is not stalled; the output register is the only buffer
// reset clears the pending flags, the output valid and the counter valid bits,
//   intervals return to their reset values; no clearing pass is needed
`default_nettype none

`include "periodic_task_release_scheduler_defines.svh"

module periodic_task_release_scheduler import ptrs_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CNT_W-1:0]     cfg_data_i,
  // input channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 kind_i,
  input  wire logic [AMT_W-1:0]     tick_amount_i,
  // output channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [ID_W-1:0]           task_id_o,
  output logic                      none_ready_o,
  output logic                      last_o
);

  // interval registers, one per task; tasks without a register keep zero
  logic [CNT_W-1:0] interval_q [NUM_TASKS];

  for (genvar g = 0; g < NUM_TASKS; g++) begin : g_interval
    if (g < NUM_REGS) begin : g_reg
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          interval_q[g] <= RESET_INTERVAL[g];
        end else if (cfg_we_i && (cfg_idx_i == CFG_IDX_W'(g))) begin
          interval_q[g] <= cfg_data_i;
        end
      end
    end else begin : g_fixed
      assign interval_q[g] = '0;
    end
  end

  // control state
  state_e               state_q, state_d;
  logic [NUM_TASKS-1:0] pend_q, pend_d;
  logic                 rd_busy_q, rd_busy_d;
  logic [TASK_W-1:0]    rd_idx_q, rd_idx_d;
  logic                 proc_vld_q;
  logic [TASK_W-1:0]    proc_idx_q;
  logic [AMT_W-1:0]     amt_q;

  // output register
  logic                 out_vld_q;
  logic [ID_W-1:0]      out_id_q, out_id_d;
  logic                 out_none_q, out_none_d;
  logic                 out_last_q, out_last_d;
  logic                 out_load;
  logic                 out_free;

  mem_req_t             mem_req;
  logic [CNT_W-1:0]     cnt_rd;
  logic [CNT_W:0]       sum_ext;
  logic [CNT_W-1:0]     cnt_new;
  logic                 in_xfer;

  // lowest pending task for dispatch
  logic [NUM_TASKS-1:0] sel_oh;
  logic [TASK_W-1:0]    sel_idx;
  logic                 sel_last;

  ptrs_count_mem u_count_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (cnt_rd)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_vld_q || !out_stall_i;

  always_comb begin
    sel_oh  = '0;
    sel_idx = '0;
    for (int i = NUM_TASKS - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        sel_oh  = NUM_TASKS'(1) << i;
        sel_idx = TASK_W'(i);
      end
    end
    sel_last = ((pend_q & ~sel_oh) == '0);
  end

  // saturating add of the tick amount to the counter just read
  assign sum_ext = {1'b0, cnt_rd} + (CNT_W + 1)'(amt_q);
  assign cnt_new = sum_ext[CNT_W] ? CNT_MAX : sum_ext[CNT_W-1:0];

  always_comb begin
    state_d    = state_q;
    pend_d     = pend_q;
    rd_busy_d  = rd_busy_q;
    rd_idx_d   = rd_idx_q;
    mem_req    = '0;
    out_load   = 1'b0;
    out_id_d   = '0;
    out_none_d = 1'b0;
    out_last_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (kind_i == KIND_TICK) begin
            state_d   = ST_TICK;
            rd_busy_d = 1'b1;
            rd_idx_d  = '0;
          end else if (pend_q == '0) begin
            state_d = ST_NONE;
          end else begin
            state_d = ST_DISP;
          end
        end
      end

      ST_TICK: begin
        // read stage walks the tasks in order
        if (rd_busy_q) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = rd_idx_q;
          if (rd_idx_q == LAST_TASK) begin
            rd_busy_d = 1'b0;
          end else begin
            rd_idx_d = rd_idx_q + 1'b1;
          end
        end
        // update stage one entry behind; pending tasks hold their count
        if (proc_vld_q && !pend_q[proc_idx_q]) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = proc_idx_q;
          mem_req.wr_data = cnt_new;
          if (cnt_new >= interval_q[proc_idx_q]) begin
            pend_d[proc_idx_q] = 1'b1;
          end
        end
        if (proc_vld_q && !rd_busy_q) begin
          state_d = ST_IDLE;
        end
      end

      ST_DISP: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_id_d        = task_to_id(sel_idx);
          out_last_d      = sel_last;
          pend_d          = pend_q & ~sel_oh;
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = sel_idx;
          mem_req.wr_data = '0;
          if (sel_last) begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_NONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_none_d = 1'b1;
          out_last_d = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pend_q     <= '0;
      rd_busy_q  <= 1'b0;
      rd_idx_q   <= '0;
      proc_vld_q <= 1'b0;
      proc_idx_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      pend_q     <= pend_d;
      rd_busy_q  <= rd_busy_d;
      rd_idx_q   <= rd_idx_d;
      proc_vld_q <= mem_req.rd_en;
      proc_idx_q <= rd_idx_q;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      amt_q <= tick_amount_i;
    end
    if (out_load) begin
      out_id_q   <= out_id_d;
      out_none_q <= out_none_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign task_id_o    = out_id_q;
  assign none_ready_o = out_none_q;
  assign last_o       = out_last_q;

  // the tick pipeline must never read and write one entry in the same cycle
  `PTRS_ASSERT_NEVER(a_no_rw_same_entry,
    mem_req.rd_en && mem_req.wr_en && (mem_req.rd_addr == mem_req.wr_addr),
    "counter read and write hit the same entry")

  // the final dispatch transfer leaves no task pending
  `PTRS_ASSERT(a_last_clears_all,
    (out_load && out_last_d && !out_none_d) |=> (pend_q == '0),
    "tasks still pending after last dispatch result")

  // a tick never drops a pending flag
  `PTRS_ASSERT(a_tick_keeps_pending,
    (state_q == ST_TICK) |=> (($past(pend_q) & ~pend_q) == '0),
    "pending flag lost during tick")

  // a none-ready result is always the only one of its dispatch
  `PTRS_ASSERT(a_none_is_last,
    (out_vld_q && out_none_q) |-> out_last_q,
    "none-ready result without last")

endmodule

`default_nettype wire

// File: dv/testbench.sv
// self-checking testbench of the periodic task release scheduler
module testbench import ptrs_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no input transfer and no register write before the run is abandoned
  localparam int WATCHDOG_LIMIT = 2000;
  // settle time after the last expected release, covers a tick still being applied
  localparam int SETTLE_CYCLES = 3 * (NUM_TASKS + 2);
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_ITEMS = 40;

  typedef struct packed {
    logic             kind;
    logic [AMT_W-1:0] amount;
  } sched_item_t;

  typedef struct packed {
    logic [ID_W-1:0] task_id;
    logic            none_ready;
    logic            last;
  } release_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CNT_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 kind_i = KIND_TICK;
  logic [AMT_W-1:0]     tick_amount_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [ID_W-1:0]      task_id_o;
  logic                 none_ready_o;
  logic                 last_o;

  periodic_task_release_scheduler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .tick_amount_i (tick_amount_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .task_id_o     (task_id_o),
    .none_ready_o  (none_ready_o),
    .last_o        (last_o)
  );

  // scheduler mirror: interval table, elapsed counters, pending flags
  logic [CNT_W-1:0] interval_cfg [NUM_TASKS];
  logic [CNT_W-1:0] elapsed_cnt [NUM_TASKS];
  logic             task_pending [NUM_TASKS];

  sched_item_t pending_items[$];
  release_t    expected_releases[$];
  sched_item_t next_item;
  release_t    seen_release;
  release_t    want_release;

  int  fail_count = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  idle_cycles = 0;
  // set for the last phase: no idling on either side
  logic quiet = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // apply one accepted item to the mirror and queue the releases it causes
  function automatic void predict_release(logic kind, logic [AMT_W-1:0] amount);
    logic [CNT_W:0] sum;
    release_t       rel;
    int             n;
    n = 0;
    if (kind == KIND_TICK) begin
      for (int t = 0; t < NUM_TASKS; t++) begin
        if (!task_pending[t]) begin
          sum = {1'b0, elapsed_cnt[t]} + amount;
          // counter saturates instead of wrapping
          elapsed_cnt[t] = (sum > CNT_MAX) ? CNT_MAX : sum[CNT_W-1:0];
          if (elapsed_cnt[t] >= interval_cfg[t]) task_pending[t] = 1'b1;
        end
      end
      return;
    end
    for (int t = 0; t < NUM_TASKS; t++) begin
      if (task_pending[t]) begin
        rel.task_id = ID_W'(t);
        rel.none_ready = 1'b0;
        rel.last = 1'b0;
        expected_releases.push_back(rel);
        task_pending[t] = 1'b0;
        elapsed_cnt[t] = '0;
        n++;
      end
    end
    if (n == 0) begin
      rel.task_id = '0;
      rel.none_ready = 1'b1;
      rel.last = 1'b1;
      expected_releases.push_back(rel);
    end else begin
      rel = expected_releases.pop_back();
      rel.last = 1'b1;
      expected_releases.push_back(rel);
    end
  endfunction

  task automatic add_item(logic kind, logic [AMT_W-1:0] amount);
    sched_item_t it;
    it.kind = kind;
    it.amount = amount;
    pending_items.push_back(it);
  endtask

  // register writes, one per cycle, only while the block is idle
  task automatic write_interval(int idx, logic [CNT_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_IDX_W'(idx);
    cfg_data_i <= value;
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until every item is sent and every release has come back, then settle
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid_i || expected_releases.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // input driver: holds an item until it transfers, idles in random bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      kind_i <= KIND_TICK;
      tick_amount_i <= '0;
      send_gap <= 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (send_gap != 0) begin
        in_valid_i <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_items.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        in_valid_i <= 1'b0;
        send_gap <= $urandom_range(0, 14);
      end else begin
        next_item = pending_items.pop_front();
        in_valid_i <= 1'b1;
        kind_i <= next_item.kind;
        tick_amount_i <= next_item.amount;
      end
    end
  end

  // output stall in random bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= $urandom_range(0, 14);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // monitor: tracks register writes and input transfers, checks each release
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i && cfg_idx_i < NUM_REGS) interval_cfg[cfg_idx_i] = cfg_data_i;
      if (in_valid_i && !in_stall_o) predict_release(kind_i, tick_amount_i);
      if (out_valid_o && !out_stall_i) begin
        seen_release = '{task_id: task_id_o, none_ready: none_ready_o, last: last_o};
        if (expected_releases.size() == 0) begin
          $display("%0t: unexpected release: task_id %0d none_ready %0b last %0b",
                   $time, task_id_o, none_ready_o, last_o);
          fail_count++;
        end else begin
          want_release = expected_releases.pop_front();
          if (seen_release.task_id !== want_release.task_id) begin
            $display("%0t: task_id mismatch: expected %0d, actual %0d",
                     $time, want_release.task_id, seen_release.task_id);
            fail_count++;
          end
          if (seen_release.none_ready !== want_release.none_ready) begin
            $display("%0t: none_ready mismatch: expected %0b, actual %0b",
                     $time, want_release.none_ready, seen_release.none_ready);
            fail_count++;
          end
          if (seen_release.last !== want_release.last) begin
            $display("%0t: last mismatch: expected %0b, actual %0b",
                     $time, want_release.last, seen_release.last);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog: an input transfer or a register write restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: watchdog: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("testbench: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [CNT_W-1:0] pick;
    for (int t = 0; t < NUM_TASKS; t++) begin
      interval_cfg[t] = (t < NUM_REGS) ? RESET_INTERVAL[t] : '0;
      elapsed_cnt[t] = '0;
      task_pending[t] = 1'b0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset intervals 5/20/200/2000: empty dispatches, zero tick, partial releases,
    // then all four tasks released by one dispatch
    add_item(KIND_DISPATCH, 8'd0);
    add_item(KIND_TICK, 8'd0);
    add_item(KIND_DISPATCH, 8'd255);
    add_item(KIND_TICK, 8'd4);
    add_item(KIND_TICK, 8'd1);
    add_item(KIND_TICK, 8'd255);
    add_item(KIND_DISPATCH, 8'd0);
    repeat (8) add_item(KIND_TICK, 8'd255);
    add_item(KIND_DISPATCH, 8'd0);
    add_item(KIND_DISPATCH, 8'd0);
    wait_drained();

    // zero interval, full-scale interval, interval of one
    write_interval(0, 16'd0);
    write_interval(1, 16'hFFFF);
    write_interval(2, 16'd1);
    write_interval(3, 16'd255);
    end_writes();
    add_item(KIND_TICK, 8'd0);
    add_item(KIND_DISPATCH, 8'd0);
    add_item(KIND_TICK, 8'd1);
    add_item(KIND_TICK, 8'd254);
    add_item(KIND_DISPATCH, 8'd0);
    // odd offset, then a run of full ticks; task 1 keeps counting without release
    add_item(KIND_TICK, 8'd7);
    for (int k = 0; k < 40; k++) begin
      add_item(KIND_TICK, 8'd255);
      if (k % 40 == 39) add_item(KIND_DISPATCH, 8'd0);
    end
    add_item(KIND_DISPATCH, 8'd0);
    wait_drained();

    // random phases, each with its own interval set; the last runs without idling
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        case ($urandom_range(0, 9))
          0:       pick = '0;
          1:       pick = CNT_MAX;
          2:       pick = 16'd1;
          3, 4, 5: pick = CNT_W'($urandom_range(1, 300));
          default: pick = CNT_W'($urandom_range(100, 1500));
        endcase
        write_interval(r, pick);
      end
      end_writes();
      quiet = (p == RANDOM_PHASES - 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 9) < 3) begin
          add_item(KIND_DISPATCH, AMT_W'($urandom()));
        end else begin
          case ($urandom_range(0, 9))
            0:       add_item(KIND_TICK, '0);
            1:       add_item(KIND_TICK, '1);
            default: add_item(KIND_TICK, AMT_W'($urandom()));
          endcase
        end
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
